/* hdl/lcg_step_distance_macros.svh */
// Assertion helpers shared by the modules of the step distance block.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef LCG_STEP_DISTANCE_MACROS_SVH
`define LCG_STEP_DISTANCE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define LSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define LSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Like LSD_ASSERT_SAME but also checked while reset is applied.
`define LSD_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/lsd_pkg.sv */
package lsd_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W  = $clog2(WORD_W);
    localparam int CFG_INDEX_W = 8;
    localparam int NUM_CELLS = WORD_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam word_t RESET_MULTIPLIER = 32'h41C6_4E6D;
    localparam word_t RESET_INCREMENT  = 32'h0000_6073;

    localparam cfg_index_t REG_MULTIPLIER = 8'd0;
    localparam cfg_index_t REG_INCREMENT  = 8'd1;

    // Everything an item carries from one cell to the next: the running state,
    // the target, the count built so far and the jump-ahead pair for this round.
    typedef struct packed {
        word_t s;
        word_t target;
        word_t count;
        word_t jm;
        word_t jc;
    } stage_t;

endpackage

/* hdl/lsd_cfg.sv */
module lsd_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  lsd_pkg::cfg_index_t  cfg_index,
    input  lsd_pkg::word_t       cfg_data,
    output lsd_pkg::word_t       multiplier,
    output lsd_pkg::word_t       increment
);
    import lsd_pkg::*;

    word_t mult_reg, mult_next;
    word_t inc_reg, inc_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        mult_next = mult_reg;
        inc_next  = inc_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_MULTIPLIER: mult_next = cfg_data;
                REG_INCREMENT:  inc_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg <= RESET_MULTIPLIER;
            inc_reg  <= RESET_INCREMENT;
        end else begin
            mult_reg <= mult_next;
            inc_reg  <= inc_next;
        end
    end

    assign multiplier = mult_reg;
    assign increment  = inc_reg;

endmodule

/* hdl/lsd_cell.sv */
`include "lcg_step_distance_macros.svh"

module lsd_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lsd_pkg::IDX_W-1:0]   bit_idx,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  lsd_pkg::stage_t             up_data,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output lsd_pkg::stage_t             dn_data
);
    import lsd_pkg::*;

    logic   valid_reg, valid_next;
    stage_t data_reg, data_next;
    logic   load;
    logic   differs;
    word_t  jump_s;

    // The cell frees up when it is empty or its content moves on this cycle.
    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb begin
        differs   = up_data.s[bit_idx] ^ up_data.target[bit_idx];
        jump_s    = up_data.s * up_data.jm + up_data.jc;
        data_next = up_data;
        if (differs) begin
            data_next.s     = jump_s;
            data_next.count = up_data.count | (WORD_W'(1) << bit_idx);
        end
        // Double the jump for the next cell.
        data_next.jc = up_data.jc * (up_data.jm + WORD_W'(1));
        data_next.jm = up_data.jm * up_data.jm;
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    `LSD_ASSERT_NEXT(a_cell_hold, valid_reg && !dn_ready, valid_reg && $stable(data_reg), "cell lost or changed an item while stalled")
    `LSD_ASSERT_NEXT(a_cell_equal, load && (up_data.s == up_data.target), (data_reg.s == $past(up_data.s)) && (data_reg.count == $past(up_data.count)), "cell moved an item whose state already matched")
    `LSD_ASSERT_NEXT(a_cell_bits, load, ((data_reg.count ^ $past(up_data.count)) & ~(WORD_W'(1) << bit_idx)) == '0, "cell touched a count bit other than its own")

endmodule

/* hdl/lcg_step_distance.sv */
// Channel   Direction  Handshake                Payload
// s_        in         s_tvalid / s_tready      s_tdata: start_state, target_state
// m_        out        m_tvalid / m_tready      m_tdata: step_count
// cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Every item passes through 32 cells, one per count bit, each registering it in
// turn before the result is offered; a new item is taken every cycle unless a
// stall on m_tready has backed the chain up to the input.
// The rate is set by the chain of cells, each holding one registered stage.
// Reset (aresetn low at a rising edge of aclk) empties all cells and restores
// the reset multiplier and increment. A stall on m_tready only backs up the
// chain as far as it is full; empty cells keep taking items until it is.
`include "lcg_step_distance_macros.svh"

module lcg_step_distance (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [2*lsd_pkg::WORD_W-1:0] s_tdata,  // start_state [31:0], target_state [63:32]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lsd_pkg::WORD_W-1:0]  m_tdata,   // step_count [31:0]
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  lsd_pkg::cfg_index_t         cfg_index,
    input  lsd_pkg::word_t              cfg_data
);
    import lsd_pkg::*;

    word_t  multiplier;
    word_t  increment;

    // Links between cells: link k feeds cell k, link NUM_CELLS is the output.
    logic   link_valid [0:NUM_CELLS];
    logic   link_ready [0:NUM_CELLS];
    stage_t link_data  [0:NUM_CELLS];

    lsd_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .multiplier (multiplier),
        .increment  (increment)
    );

    // An item enters with the single-step pair; every cell doubles the pair
    // on the way, so the pair an item carries always matches its round even
    // if the registers are rewritten between items.
    always_comb begin
        link_data[0].s      = s_tdata[WORD_W-1:0];
        link_data[0].target = s_tdata[2*WORD_W-1:WORD_W];
        link_data[0].count  = '0;
        link_data[0].jm     = multiplier;
        link_data[0].jc     = increment;
    end

    assign link_valid[0] = s_tvalid;
    assign s_tready      = link_ready[0];

    // Cell k settles bit k of the count.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        lsd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .bit_idx  (IDX_W'(g)),
            .up_valid (link_valid[g]),
            .up_ready (link_ready[g]),
            .up_data  (link_data[g]),
            .dn_valid (link_valid[g+1]),
            .dn_ready (link_ready[g+1]),
            .dn_data  (link_data[g+1])
        );
    end

    assign m_tvalid              = link_valid[NUM_CELLS];
    assign link_ready[NUM_CELLS] = m_tready;
    assign m_tdata               = link_data[NUM_CELLS].count;

    `LSD_ASSERT_SAME(a_top_stall, !s_tready, m_tvalid && !m_tready, "input stalled while the output was not blocked")
    `LSD_ASSERT_SAME(a_top_empty, !m_tvalid, s_tready, "input stalled with an empty output stage")
    `LSD_ASSERT_ALWAYS(a_top_reset, !aresetn, ##1 !m_tvalid, "result offered right after reset")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import lsd_pkg::*;

    // An index past the last register; writes to it must change nothing.
    localparam cfg_index_t REG_NONE = 8'hFF;

    // Cycles without any accepted item or register write before the run is abandoned.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    // The pipeline is 32 cells deep; this covers it with a small margin.
    localparam int SETTLE_CYCLES = 40;

    // One input item: start_state in the low word, target_state in the high word.
    typedef struct packed {
        word_t target_state;
        word_t start_state;
    } seed_pair_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [2*WORD_W-1:0] s_tdata = '0;  // start_state [31:0], target_state [63:32]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;         // step_count [31:0]
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = '0;
    word_t cfg_data = '0;

    // Our own copy of the generator constants, updated as each write is accepted.
    word_t gen_mult = RESET_MULTIPLIER;
    word_t gen_inc = RESET_INCREMENT;

    seed_pair_t pending_pairs[$];
    word_t expected_counts[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_count = 0;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;
    bit s_item_taken = 1'b0;

    lcg_step_distance dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Settle the count bit by bit from the bottom: bit b is set when the running state
    // still disagrees with the target at bit b, in which case a jump of 2^b steps
    // is applied. The jump pair is doubled after every round.
    function automatic word_t steps_between(word_t from_state, word_t to_state);
        word_t jm = gen_mult;
        word_t jc = gen_inc;
        word_t s = from_state;
        word_t n = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (s[b] != to_state[b]) begin
                s = s * jm + jc;
                n[b] = 1'b1;
            end
            jc = jc * (jm + 32'd1);
            jm = jm * jm;
        end
        return n;
    endfunction

    // Advance a state by a given number of single steps, so that the stimulus can
    // build targets that really lie on the generator's orbit.
    function automatic word_t jump_state(word_t s, word_t steps);
        word_t jm = gen_mult;
        word_t jc = gen_inc;
        word_t r = s;
        for (int b = 0; b < WORD_W; b++) begin
            if (steps[b])
                r = r * jm + jc;
            jc = jc * (jm + 32'd1);
            jm = jm * jm;
        end
        return r;
    endfunction

    // Mostly reachable targets, some equal states and some arbitrary targets.
    function automatic seed_pair_t random_pair();
        seed_pair_t p;
        int unsigned pick;
        p.start_state = $urandom();
        pick = $urandom_range(99);
        if (pick < 60)
            p.target_state = jump_state(p.start_state, $urandom());
        else if (pick < 78)
            p.target_state = jump_state(p.start_state, $urandom_range(300));
        else if (pick < 83)
            p.target_state = p.start_state;
        else
            p.target_state = $urandom();
        return p;
    endfunction

    function automatic word_t full_period_mult();
        return ($urandom() & ~32'h3) | 32'h1;
    endfunction

    // Input driver: holds an offered item until it is taken, then either offers
    // the next pending item or idles.
    always @(negedge aclk) begin : item_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_item_taken) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pairs.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off that this process times
    // on its own so that the whole chain fills up and input backs up.
    always @(negedge aclk) begin : result_receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_req && !hold_off_done) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
                hold_off_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: records accepted items, checks results in order and watches for a hang.
    always @(posedge aclk) begin : monitor
        seed_pair_t pair;
        word_t want;
        s_item_taken = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_item_taken) begin
                pair = seed_pair_t'(s_tdata);
                expected_counts.push_back(steps_between(pair.start_state, pair.target_state));
            end
            if (m_tvalid && m_tready) begin
                if (expected_counts.size() == 0) begin
                    $error("step_count: no result expected, actual %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_counts.pop_front();
                    if (m_tdata !== want) begin
                        $error("step_count mismatch: expected %h, actual %h", want, m_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_item_taken || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Register write; only called while nothing is in flight.
    task automatic write_reg(cfg_index_t idx, word_t val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_MULTIPLIER)
            gen_mult = val;
        else if (idx == REG_INCREMENT)
            gen_inc = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_generator(word_t mult, word_t inc);
        write_reg(REG_MULTIPLIER, mult);
        write_reg(REG_INCREMENT, inc);
    endtask

    // Wait until every item has been taken and every result has come back.
    task automatic drain();
        while (pending_pairs.size() != 0 || s_tvalid || expected_counts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_random(int unsigned send_pct, int unsigned recv_pct, int n);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) pending_pairs.push_back(random_pair());
        drain();
    endtask

    task automatic queue_pair(word_t start_state, word_t target_state);
        seed_pair_t p;
        p.start_state = start_state;
        p.target_state = target_state;
        pending_pairs.push_back(p);
    endtask

    initial begin : sequencer
        word_t seed;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed items against the reset constants, nothing idling: field extremes,
        // equal states, single and full-range jumps, and walking bits.
        queue_pair(32'h0000_0000, 32'h0000_0000);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
        queue_pair(32'h1234_5678, 32'h1234_5678);
        queue_pair(32'h0000_0000, jump_state(32'h0000_0000, 32'd1));
        queue_pair(32'h0000_0000, jump_state(32'h0000_0000, 32'h8000_0000));
        queue_pair(32'hFFFF_FFFF, jump_state(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_pair(32'hA5A5_A5A5, jump_state(32'hA5A5_A5A5, 32'h5A5A_5A5A));
        for (int b = 0; b < WORD_W; b += 4) begin
            seed = 32'h1 << b;
            queue_pair(seed, ~seed);
        end
        queue_pair(32'h8000_0000, 32'h7FFF_FFFF);
        seed = $urandom();
        queue_pair(seed, jump_state(seed, $urandom()));
        run_random(0, 0, 0);

        // Degenerate generator: everything collapses to the increment, which is zero.
        set_generator(32'h0000_0000, 32'h0000_0000);
        run_random(47, 0, 100);

        // All-ones constants: multiplier is 3 mod 4, so no full period.
        set_generator(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(0, 47, 120);

        set_generator(full_period_mult(), $urandom() | 32'h1);
        run_random(8, 8, 150);

        // Long receiver hold-off while the sender keeps offering items back to back.
        set_generator(full_period_mult(), $urandom() | 32'h1);
        hold_off_req = 1'b1;
        run_random(0, 0, 100);

        // Writes past the last register must be ignored by the block.
        set_generator($urandom(), $urandom());
        write_reg(REG_NONE, $urandom());
        write_reg(cfg_index_t'($urandom_range(REG_INCREMENT + 1, REG_NONE - 1)), $urandom());
        run_random(8, 8, 150);

        // Unit multiplier and increment: the count is simply the state difference.
        set_generator(32'h0000_0001, 32'h0000_0001);
        run_random(47, 0, 100);

        set_generator(RESET_MULTIPLIER, RESET_INCREMENT);
        run_random(0, 0, 150);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_counts.size() != 0) begin
            $error("step_count: %0d results never arrived", expected_counts.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
